[design/ppdb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ppdb_pkg
// Shared register map, reset values and fixed-point constants of the
// point projection depth buffer.
// ----------------------------------------------------------------------------
package ppdb_pkg;

    typedef enum logic [2:0] {
        CFG_FOCAL_X      = 3'd0,
        CFG_FOCAL_Y      = 3'd1,
        CFG_CENTER_X     = 3'd2,
        CFG_CENTER_Y     = 3'd3,
        CFG_IMAGE_WIDTH  = 3'd4,
        CFG_IMAGE_HEIGHT = 3'd5,
        CFG_SPARE_6      = 3'd6,
        CFG_SPARE_7      = 3'd7
    } cfg_idx_t;

    localparam int unsigned CFG_ADDR_BITS = 5;

    localparam logic [23:0] FOCAL_RESET  = 24'd131072;
    localparam logic [23:0] CENTER_RESET = 24'd65536;
    localparam logic [9:0]  SIZE_RESET   = 10'd512;

    localparam logic [63:0] Q_SAT   = 64'h0000_0100_0000_0000;
    localparam logic [43:0] Q_HALF  = 44'h0000_0000_8000;

endpackage
`default_nettype wire

[design/point_projection_depth_buffer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// point_projection_depth_buffer
// Projects camera-frame points through a pinhole model into a depth buffer
// with a point-index map, and serves read-and-clear requests per pixel.
// A project beat runs the 64-step serial divider, then updates the depth of the
// truncated pixel, and of the rounded pixel too when it differs from the
// truncated one; a beat with non-positive depth or an out-of-store read answers straight from idle.
// A read beat does one memory read, then write-back of the cleared
// entry. One beat is in flight at a time; results cannot be stalled.
// After reset the depth memory is cleared, one entry per cycle, over all
// MAX_COLS*MAX_ROWS entries, with busy high; configuration is always taken.
// ----------------------------------------------------------------------------
module point_projection_depth_buffer #(
    parameter int MAX_COLS   = 512,
    parameter int MAX_ROWS   = 512,
    parameter int INDEX_BITS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [ppdb_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        opcode,
    input  wire logic [31:0] point_x,
    input  wire logic [31:0] point_y,
    input  wire logic [31:0] point_z,
    input  wire logic [23:0] point_number,
    input  wire logic [8:0]  read_col,
    input  wire logic [8:0]  read_row,
    output logic             done,
    output logic             was_read,
    output logic             landed,
    output logic             map_written,
    output logic      [8:0]  written_col,
    output logic      [8:0]  written_row,
    output logic      [31:0] depth_out,
    output logic             index_valid,
    output logic      [23:0] index_out
);
    import ppdb_pkg::*;

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL, S_DIV, S_POS1, S_POS2, S_POS3, S_POS4,
        S_LO_RD, S_LO_WR, S_HI_RD, S_HI_WR, S_RD_RD, S_RD_WR
    } state_t;

    state_t state_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [5:0]    div_cnt_reg;

    logic [23:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [9:0]  width_reg, height_reg;

    logic        done_reg, was_read_reg, landed_reg, map_written_reg, index_valid_reg;
    logic [8:0]  written_col_reg, written_row_reg;
    logic [31:0] depth_out_reg;
    logic [23:0] index_out_reg;

    logic [31:0] x_reg, y_reg, z_reg;
    logic [INDEX_BITS-1:0] number_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [63:0] num_x_reg, num_y_reg, q_x_reg, q_y_reg;
    logic [31:0] rem_x_reg, rem_y_reg;
    logic signed [43:0] sd_x_reg, sd_y_reg;
    logic signed [43:0] dlo_x_reg, dlo_y_reg, dhi_x_reg, dhi_y_reg;
    logic signed [27:0] xl_reg, yl_reg, xh_reg, yh_reg;
    logic [AW-1:0] lo_addr_reg, hi_addr_reg;
    logic lo_in_reg, hi_in_reg, distinct_reg;

    logic [32:0] dmem [DEPTH];
    logic [INDEX_BITS-1:0] imem [DEPTH];
    logic [32:0] dmem_rd_reg;
    logic [INDEX_BITS-1:0] imem_rd_reg;

    logic        accept, cfg_write, rd_in_store, z_ok;
    logic        mem_we, idx_we;
    logic [AW-1:0] mem_addr;
    logic [32:0] mem_wdata;
    logic [31:0] depth_upd;
    logic [31:0] mag_x, mag_y;
    logic [55:0] prod_x, prod_y;
    logic [31:0] r2_x, r2_y;
    logic        ge_x, ge_y;
    logic [40:0] qs_x, qs_y;
    logic [12:0] w_eff, h_eff;
    logic signed [27:0] xl_t, yl_t, xh_t, yh_t;
    logic        lo_in_t, hi_in_t;
    logic [31:0] number_ext, index_ext;

    function automatic logic signed [27:0] trunc_q16(input logic signed [43:0] d);
        logic [43:0] a;
        logic [27:0] s;
        a = d[43] ? 44'(-d) : 44'(d);
        s = a[43:16];
        return d[43] ? 28'(-s) : 28'(s);
    endfunction

    function automatic logic in_image(input logic signed [27:0] c, input logic signed [27:0] r,
                                      input logic [12:0] w, input logic [12:0] h);
        return !c[27] && !r[27] && (c[26:0] < 27'(w)) && (r[26:0] < 27'(h));
    endfunction

    assign pready      = 1'b1;
    assign busy        = (state_reg != S_IDLE);
    assign accept      = start && !busy;
    assign cfg_write   = psel && penable && pwrite && pready;
    assign rd_in_store = (32'(read_col) < 32'(MAX_COLS)) && (32'(read_row) < 32'(MAX_ROWS));
    assign z_ok        = (point_z != 32'd0) && !point_z[31];

    assign done        = done_reg;
    assign was_read    = was_read_reg;
    assign landed      = landed_reg;
    assign map_written = map_written_reg;
    assign written_col = written_col_reg;
    assign written_row = written_row_reg;
    assign depth_out   = depth_out_reg;
    assign index_valid = index_valid_reg;
    assign index_out   = index_out_reg;

    always_comb
    begin
        case (cfg_idx_t'(paddr[4:2]))
            CFG_FOCAL_X:      prdata = 32'(focal_x_reg);
            CFG_FOCAL_Y:      prdata = 32'(focal_y_reg);
            CFG_CENTER_X:     prdata = 32'(center_x_reg);
            CFG_CENTER_Y:     prdata = 32'(center_y_reg);
            CFG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            CFG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= FOCAL_RESET;
            focal_y_reg  <= FOCAL_RESET;
            center_x_reg <= CENTER_RESET;
            center_y_reg <= CENTER_RESET;
            width_reg    <= SIZE_RESET;
            height_reg   <= SIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(paddr[4:2]))
                CFG_FOCAL_X:      focal_x_reg  <= pwdata[23:0];
                CFG_FOCAL_Y:      focal_y_reg  <= pwdata[23:0];
                CFG_CENTER_X:     center_x_reg <= pwdata[23:0];
                CFG_CENTER_Y:     center_y_reg <= pwdata[23:0];
                CFG_IMAGE_WIDTH:  width_reg    <= pwdata[9:0];
                CFG_IMAGE_HEIGHT: height_reg   <= pwdata[9:0];
                default:          ;
            endcase
        end
    end

    assign w_eff = (32'(width_reg) < 32'(MAX_COLS)) ? 13'(width_reg) : 13'(MAX_COLS);
    assign h_eff = (32'(height_reg) < 32'(MAX_ROWS)) ? 13'(height_reg) : 13'(MAX_ROWS);

    assign mag_x  = x_reg[31] ? 32'(32'd0 - x_reg) : x_reg;
    assign mag_y  = y_reg[31] ? 32'(32'd0 - y_reg) : y_reg;
    assign prod_x = 56'(focal_x_reg) * 56'(mag_x);
    assign prod_y = 56'(focal_y_reg) * 56'(mag_y);

    assign r2_x = {rem_x_reg[30:0], num_x_reg[63]};
    assign r2_y = {rem_y_reg[30:0], num_y_reg[63]};
    assign ge_x = (r2_x >= z_reg);
    assign ge_y = (r2_y >= z_reg);

    assign qs_x = (q_x_reg > Q_SAT) ? Q_SAT[40:0] : q_x_reg[40:0];
    assign qs_y = (q_y_reg > Q_SAT) ? Q_SAT[40:0] : q_y_reg[40:0];

    assign xl_t = trunc_q16(dlo_x_reg);
    assign yl_t = trunc_q16(dlo_y_reg);
    assign xh_t = trunc_q16(dhi_x_reg);
    assign yh_t = trunc_q16(dhi_y_reg);

    assign lo_in_t = in_image(xl_reg, yl_reg, w_eff, h_eff);
    assign hi_in_t = in_image(xh_reg, yh_reg, w_eff, h_eff);

    assign depth_upd = ((dmem_rd_reg[31:0] == 32'd0) || (z_reg < dmem_rd_reg[31:0]))
                       ? z_reg : dmem_rd_reg[31:0];

    assign number_ext = 32'(point_number);
    assign index_ext  = 32'(imem_rd_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        idx_we    = 1'b0;
        mem_addr  = lo_addr_reg;
        mem_wdata = 33'd0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
            end
            S_RD_RD:
            begin
                mem_addr = rd_addr_reg;
            end
            S_RD_WR:
            begin
                mem_we   = 1'b1;
                mem_addr = rd_addr_reg;
            end
            S_LO_WR:
            begin
                mem_we    = lo_in_reg;
                idx_we    = lo_in_reg;
                mem_wdata = {1'b1, depth_upd};
            end
            S_HI_RD:
            begin
                mem_addr = hi_addr_reg;
            end
            S_HI_WR:
            begin
                mem_we    = hi_in_reg;
                mem_addr  = hi_addr_reg;
                mem_wdata = {dmem_rd_reg[32], depth_upd};
            end
            default:
            begin
                mem_addr = lo_addr_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dmem[mem_addr] <= mem_wdata;
        end
        dmem_rd_reg <= dmem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (idx_we)
        begin
            imem[mem_addr] <= number_reg;
        end
        imem_rd_reg <= imem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_reg       <= point_x;
                    y_reg       <= point_y;
                    z_reg       <= point_z;
                    number_reg  <= number_ext[INDEX_BITS-1:0];
                    rd_addr_reg <= AW'(AW'(read_row) * AW'(MAX_COLS) + AW'(read_col));
                end
            end
            S_MUL:
            begin
                num_x_reg <= {prod_x, 8'd0};
                num_y_reg <= {prod_y, 8'd0};
                rem_x_reg <= 32'd0;
                rem_y_reg <= 32'd0;
                q_x_reg   <= 64'd0;
                q_y_reg   <= 64'd0;
            end
            S_DIV:
            begin
                num_x_reg <= {num_x_reg[62:0], 1'b0};
                num_y_reg <= {num_y_reg[62:0], 1'b0};
                rem_x_reg <= ge_x ? 32'(r2_x - z_reg) : r2_x;
                rem_y_reg <= ge_y ? 32'(r2_y - z_reg) : r2_y;
                q_x_reg   <= {q_x_reg[62:0], ge_x};
                q_y_reg   <= {q_y_reg[62:0], ge_y};
            end
            S_POS1:
            begin
                sd_x_reg <= x_reg[31] ? -$signed(44'(qs_x)) : $signed(44'(qs_x));
                sd_y_reg <= y_reg[31] ? -$signed(44'(qs_y)) : $signed(44'(qs_y));
            end
            S_POS2:
            begin
                dlo_x_reg <= sd_x_reg + $signed(44'({center_x_reg, 8'd0}));
                dlo_y_reg <= sd_y_reg + $signed(44'({center_y_reg, 8'd0}));
                dhi_x_reg <= sd_x_reg + $signed(44'({center_x_reg, 8'd0}))
                             + $signed(Q_HALF);
                dhi_y_reg <= sd_y_reg + $signed(44'({center_y_reg, 8'd0}))
                             + $signed(Q_HALF);
            end
            S_POS3:
            begin
                xl_reg <= xl_t;
                yl_reg <= yl_t;
                xh_reg <= xh_t;
                yh_reg <= yh_t;
            end
            S_POS4:
            begin
                lo_in_reg    <= lo_in_t;
                hi_in_reg    <= hi_in_t;
                distinct_reg <= (xl_reg != xh_reg) || (yl_reg != yh_reg);
                lo_addr_reg  <= AW'(AW'(yl_reg) * AW'(MAX_COLS) + AW'(xl_reg));
                hi_addr_reg  <= AW'(AW'(yh_reg) * AW'(MAX_COLS) + AW'(xh_reg));
            end
            default:
            begin
                rd_addr_reg <= rd_addr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            div_cnt_reg     <= '0;
            done_reg        <= 1'b0;
            was_read_reg    <= 1'b0;
            landed_reg      <= 1'b0;
            map_written_reg <= 1'b0;
            written_col_reg <= 9'd0;
            written_row_reg <= 9'd0;
            depth_out_reg   <= 32'd0;
            index_valid_reg <= 1'b0;
            index_out_reg   <= 24'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= AW'(clr_cnt_reg + 1'b1);
                    if (clr_cnt_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (opcode && rd_in_store)
                        begin
                            state_reg <= S_RD_RD;
                        end
                        else if (!opcode && z_ok)
                        begin
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            done_reg        <= 1'b1;
                            was_read_reg    <= opcode;
                            landed_reg      <= 1'b0;
                            map_written_reg <= 1'b0;
                            written_col_reg <= 9'd0;
                            written_row_reg <= 9'd0;
                            depth_out_reg   <= 32'd0;
                            index_valid_reg <= 1'b0;
                            index_out_reg   <= 24'd0;
                        end
                    end
                end
                S_MUL:
                begin
                    div_cnt_reg <= '1;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    div_cnt_reg <= 6'(div_cnt_reg - 1'b1);
                    if (div_cnt_reg == 6'd0)
                    begin
                        state_reg <= S_POS1;
                    end
                end
                S_POS1:  state_reg <= S_POS2;
                S_POS2:  state_reg <= S_POS3;
                S_POS3:  state_reg <= S_POS4;
                S_POS4:  state_reg <= S_LO_RD;
                S_LO_RD: state_reg <= S_LO_WR;
                S_HI_RD: state_reg <= S_HI_WR;
                S_LO_WR, S_HI_WR:
                begin
                    if (state_reg == S_LO_WR && distinct_reg)
                    begin
                        state_reg <= S_HI_RD;
                    end
                    else
                    begin
                        state_reg       <= S_IDLE;
                        done_reg        <= 1'b1;
                        was_read_reg    <= 1'b0;
                        landed_reg      <= lo_in_reg || (distinct_reg && hi_in_reg);
                        map_written_reg <= lo_in_reg;
                        written_col_reg <= lo_in_reg ? xl_reg[8:0] : 9'd0;
                        written_row_reg <= lo_in_reg ? yl_reg[8:0] : 9'd0;
                        depth_out_reg   <= 32'd0;
                        index_valid_reg <= 1'b0;
                        index_out_reg   <= 24'd0;
                    end
                end
                S_RD_RD: state_reg <= S_RD_WR;
                S_RD_WR:
                begin
                    state_reg       <= S_IDLE;
                    done_reg        <= 1'b1;
                    was_read_reg    <= 1'b1;
                    landed_reg      <= 1'b0;
                    map_written_reg <= 1'b0;
                    written_col_reg <= 9'd0;
                    written_row_reg <= 9'd0;
                    depth_out_reg   <= dmem_rd_reg[31:0];
                    index_valid_reg <= dmem_rd_reg[32];
                    index_out_reg   <= dmem_rd_reg[32] ? index_ext[23:0] : 24'd0;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
        else $error("accepted beat neither started work nor produced a result");

    a_hi_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HI_RD) |-> (distinct_reg && (lo_addr_reg != hi_addr_reg)))
        else $error("second depth update targets the truncated pixel");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(was_read && (landed || map_written)))
        else $error("read result carries projection flags");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_cnt_reg == 6'd0) |=> (state_reg == S_POS1))
        else $error("divider did not hand over after its last step");

endmodule
`default_nettype wire

[tb/sv/tb_point_projection_depth_buffer.sv]
// ----------------------------------------------------------------------------
// tb_point_projection_depth_buffer
// Self-checking testbench for the point projection depth buffer. A queue of
// command beats (project and read-and-clear) drives the block with random
// gaps. A local model of the depth and index stores predicts every result,
// and a monitor compares each result field by field. Several register
// settings, extremes included, are applied between phases while idle.
// ----------------------------------------------------------------------------
module tb_point_projection_depth_buffer;
    import ppdb_pkg::*;

    typedef struct {
        bit        op;
        bit [31:0] px;
        bit [31:0] py;
        bit [31:0] pz;
        bit [23:0] num;
        bit [8:0]  col;
        bit [8:0]  row;
        int        gap;
    } beat_t;

    typedef struct {
        bit        was_read;
        bit        landed;
        bit        map_written;
        bit [8:0]  written_col;
        bit [8:0]  written_row;
        bit [31:0] depth_out;
        bit        index_valid;
        bit [23:0] index_out;
    } outcome_t;

    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int DRAIN_CYCLES   = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic        opcode = 1'b0;
    logic [31:0] point_x = '0;
    logic [31:0] point_y = '0;
    logic [31:0] point_z = '0;
    logic [23:0] point_number = '0;
    logic [8:0]  read_col = '0;
    logic [8:0]  read_row = '0;
    logic        done;
    logic        was_read;
    logic        landed;
    logic        map_written;
    logic [8:0]  written_col;
    logic [8:0]  written_row;
    logic [31:0] depth_out;
    logic        index_valid;
    logic [23:0] index_out;

    point_projection_depth_buffer dut (.*);

    always #10 clk = ~clk;

    beat_t    command_q[$];
    outcome_t pending_outcomes[$];
    bit [31:0] depth_mem[int];
    bit [23:0] index_mem[int];
    bit        index_set[int];
    bit [23:0] focal_x_r = FOCAL_RESET;
    bit [23:0] focal_y_r = FOCAL_RESET;
    bit [23:0] center_x_r = CENTER_RESET;
    bit [23:0] center_y_r = CENTER_RESET;
    bit [9:0]  width_r = SIZE_RESET;
    bit [9:0]  height_r = SIZE_RESET;
    int  error_count = 0;
    int  gap_left = 0;
    int  quiet_cycles = 0;
    bit  beat_taken = 1'b0;
    bit  burst_mode = 1'b0;

    function automatic longint pixel_pos(bit [23:0] f, bit [23:0] c, bit [31:0] coord,
                                         bit [63:0] zmag);
        bit        neg;
        bit [63:0] mag;
        bit [63:0] q;
        longint    d;
        neg = coord[31];
        mag = neg ? (64'h1_0000_0000 - {32'b0, coord}) : {32'b0, coord};
        q = (({40'b0, f} * mag) << 8) / zmag;
        if (q > Q_SAT)
            q = Q_SAT;
        d = neg ? -longint'(q) : longint'(q);
        return d + (longint'(c) << 8);
    endfunction

    function automatic longint to_pixel(longint d);
        return d < 0 ? -((-d) >>> 16) : (d >>> 16);
    endfunction

    function automatic bit deepen_pixel(longint c, longint r, bit [31:0] z);
        longint w;
        longint h;
        int     a;
        w = width_r < 512 ? width_r : 512;
        h = height_r < 512 ? height_r : 512;
        if (c < 0 || c >= w || r < 0 || r >= h)
            return 1'b0;
        a = int'(r * 512 + c);
        if (!depth_mem.exists(a) || depth_mem[a] == 0 || z < depth_mem[a])
            depth_mem[a] = z;
        return 1'b1;
    endfunction

    function automatic outcome_t predict_outcome(beat_t b);
        outcome_t o;
        longint   dx;
        longint   dy;
        longint   xl;
        longint   yl;
        longint   xh;
        longint   yh;
        bit       low_in;
        bit       hit;
        int       a;
        o = '{default: 0};
        if (b.op)
        begin
            o.was_read = 1'b1;
            a = b.row * 512 + b.col;
            o.depth_out = depth_mem.exists(a) ? depth_mem[a] : 32'd0;
            o.index_valid = index_set.exists(a) ? index_set[a] : 1'b0;
            o.index_out = o.index_valid ? index_mem[a] : 24'd0;
            depth_mem[a] = 32'd0;
            index_set[a] = 1'b0;
            return o;
        end
        if (b.pz == 0 || b.pz[31])
            return o;
        dx = pixel_pos(focal_x_r, center_x_r, b.px, {32'b0, b.pz});
        dy = pixel_pos(focal_y_r, center_y_r, b.py, {32'b0, b.pz});
        xl = to_pixel(dx);
        yl = to_pixel(dy);
        xh = to_pixel(dx + 64'sh8000);
        yh = to_pixel(dy + 64'sh8000);
        low_in = deepen_pixel(xl, yl, b.pz);
        hit = low_in;
        if (xl != xh || yl != yh)
            if (deepen_pixel(xh, yh, b.pz))
                hit = 1'b1;
        o.landed = hit;
        if (low_in)
        begin
            a = int'(yl * 512 + xl);
            index_mem[a] = b.num;
            index_set[a] = 1'b1;
            o.map_written = 1'b1;
            o.written_col = xl[8:0];
            o.written_row = yl[8:0];
        end
        return o;
    endfunction

    always @(posedge clk)
    begin
        outcome_t exp_o;
        beat_t    b;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $error("result with no beat outstanding");
                    error_count++;
                end
                else
                begin
                    exp_o = pending_outcomes.pop_front();
                    if (was_read !== exp_o.was_read)
                    begin
                        $error("was_read exp %0h got %0h", exp_o.was_read, was_read);
                        error_count++;
                    end
                    if (landed !== exp_o.landed)
                    begin
                        $error("landed exp %0h got %0h", exp_o.landed, landed);
                        error_count++;
                    end
                    if (map_written !== exp_o.map_written)
                    begin
                        $error("map_written exp %0h got %0h", exp_o.map_written, map_written);
                        error_count++;
                    end
                    if (written_col !== exp_o.written_col)
                    begin
                        $error("written_col exp %0d got %0d", exp_o.written_col, written_col);
                        error_count++;
                    end
                    if (written_row !== exp_o.written_row)
                    begin
                        $error("written_row exp %0d got %0d", exp_o.written_row, written_row);
                        error_count++;
                    end
                    if (depth_out !== exp_o.depth_out)
                    begin
                        $error("depth_out exp %0h got %0h", exp_o.depth_out, depth_out);
                        error_count++;
                    end
                    if (index_valid !== exp_o.index_valid)
                    begin
                        $error("index_valid exp %0h got %0h", exp_o.index_valid, index_valid);
                        error_count++;
                    end
                    if (index_out !== exp_o.index_out)
                    begin
                        $error("index_out exp %0h got %0h", exp_o.index_out, index_out);
                        error_count++;
                    end
                end
            end
            beat_taken <= start && !busy;
            if (start && !busy)
            begin
                b.op = opcode;
                b.px = point_x;
                b.py = point_y;
                b.pz = point_z;
                b.num = point_number;
                b.col = read_col;
                b.row = read_row;
                b.gap = 0;
                pending_outcomes.insert(pending_outcomes.size(), predict_outcome(b));
            end
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_point_projection_depth_buffer: FAIL");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        beat_t b;
        if (rst_n)
        begin
            if (start && beat_taken)
            begin
                start <= 1'b0;
            end
            else if (!start)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                end
                else if (command_q.size() > 0)
                begin
                    b = command_q.pop_front();
                    opcode <= b.op;
                    point_x <= b.px;
                    point_y <= b.py;
                    point_z <= b.pz;
                    point_number <= b.num;
                    read_col <= b.col;
                    read_row <= b.row;
                    gap_left <= b.gap;
                    start <= 1'b1;
                end
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, bit [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            CFG_FOCAL_X:      focal_x_r = value[23:0];
            CFG_FOCAL_Y:      focal_y_r = value[23:0];
            CFG_CENTER_X:     center_x_r = value[23:0];
            CFG_CENTER_Y:     center_y_r = value[23:0];
            CFG_IMAGE_WIDTH:  width_r = value[9:0];
            CFG_IMAGE_HEIGHT: height_r = value[9:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(bit [23:0] fx, bit [23:0] fy, bit [23:0] cx,
                                 bit [23:0] cy, bit [9:0] w, bit [9:0] h);
        write_reg(CFG_FOCAL_X, 32'(fx));
        write_reg(CFG_FOCAL_Y, 32'(fy));
        write_reg(CFG_CENTER_X, 32'(cx));
        write_reg(CFG_CENTER_Y, 32'(cy));
        write_reg(CFG_IMAGE_WIDTH, 32'(w));
        write_reg(CFG_IMAGE_HEIGHT, 32'(h));
    endtask

    task automatic wait_idle();
        while (command_q.size() > 0 || start || pending_outcomes.size() > 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_gap();
        return burst_mode ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic queue_point(bit [31:0] x, bit [31:0] y, bit [31:0] z, bit [23:0] n);
        beat_t b;
        b = '{op: 1'b0, px: x, py: y, pz: z, num: n, col: 9'd0, row: 9'd0, gap: pick_gap()};
        command_q.insert(command_q.size(), b);
    endtask

    task automatic queue_read(bit [8:0] c, bit [8:0] r);
        beat_t b;
        b = '{op: 1'b1, px: 32'd0, py: 32'd0, pz: 32'd0, num: 24'd0, col: c, row: r,
              gap: pick_gap()};
        command_q.insert(command_q.size(), b);
    endtask

    function automatic bit [31:0] coord_for(real target, bit [23:0] f, bit [23:0] c,
                                            bit [31:0] z);
        real r;
        if (f == 0)
            return $urandom();
        r = (target - c / 256.0) * (z / 65536.0) / (f / 256.0) * 65536.0;
        if (r > 2147483647.0)
            r = 2147483647.0;
        if (r < -2147483648.0)
            r = -2147483648.0;
        return $rtoi(r);
    endfunction

    task automatic random_phase(int count);
        beat_t b;
        int    sel;
        int    span_c;
        int    span_r;
        real   tu;
        real   tv;
        bit [31:0] z;
        span_c = width_r < 16 ? width_r : 16;
        span_r = height_r < 16 ? height_r : 16;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 12)
            begin
                b.op = 1'($urandom());
                b.px = $urandom();
                b.py = $urandom();
                b.pz = $urandom();
                b.num = 24'($urandom());
                b.col = 9'($urandom());
                b.row = 9'($urandom());
                b.gap = pick_gap();
                command_q.insert(command_q.size(), b);
            end
            else if (sel < 37)
            begin
                if ($urandom_range(0, 3) != 0)
                    queue_read(9'($urandom_range(0, span_c)), 9'($urandom_range(0, span_r)));
                else
                    queue_read(9'($urandom()), 9'($urandom()));
            end
            else
            begin
                z = $urandom_range(32'h0000_4000, 32'h0010_0000);
                if ($urandom_range(0, 4) == 0)
                begin
                    tu = $urandom_range(0, width_r + 4) - 2.0 + $urandom_range(0, 99) / 100.0;
                    tv = $urandom_range(0, height_r + 4) - 2.0 + $urandom_range(0, 99) / 100.0;
                end
                else
                begin
                    tu = $urandom_range(0, span_c + 1) - 1.0 + $urandom_range(0, 99) / 100.0;
                    tv = $urandom_range(0, span_r + 1) - 1.0 + $urandom_range(0, 99) / 100.0;
                end
                queue_point(coord_for(tu, focal_x_r, center_x_r, z),
                            coord_for(tv, focal_y_r, center_y_r, z), z, 24'($urandom()));
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Default settings: u = 512*x/z + 256, so x = 0 at z = 1.0 lands on column 256.
        burst_mode = 1'b1;
        queue_point(32'd0, 32'd0, 32'h0001_0000, 24'd5);
        queue_point(32'd0, 32'd0, 32'h0002_0000, 24'd6);
        queue_point(32'd0, 32'd0, 32'h0000_8000, 24'd7);
        queue_read(9'd1, 9'd1);
        queue_read(9'd1, 9'd1);
        queue_point(32'd0, 32'd0, 32'd0, 24'd8);
        queue_point(32'd0, 32'd0, 32'hFFFF_0000, 24'd9);
        queue_point(32'd0, 32'd0, 32'h8000_0000, 24'd10);
        queue_point(32'd19661, 32'd0, 32'h0001_0000, 24'd11);
        queue_point(-32'sd72090, 32'd0, 32'h0001_0000, 24'd12);
        queue_point(-32'sd52429, -32'sd52429, 32'h0001_0000, 24'd13);
        queue_point(32'h7FFF_FFFF, 32'd0, 32'h0000_0001, 24'd14);
        queue_point(32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 24'd15);
        queue_point(32'd0, 32'd0, 32'h7FFF_FFFF, 24'hFF_FFFF);
        queue_point(32'd1, 32'd1, 32'd1, 24'd16);
        queue_point(32'd16711680, 32'd16711680, 32'h0001_0000, 24'd17);
        queue_read(9'd0, 9'd1);
        queue_read(9'd2, 9'd1);
        queue_read(9'd0, 9'd0);
        queue_read(9'd511, 9'd511);
        queue_read(9'd1, 9'd1);
        queue_read(9'd2, 9'd2);
        wait_idle();

        load_settings(24'h01_0000, 24'h01_0000, 24'h01_0000, 24'h01_0000, 10'd512, 10'd512);
        random_phase(140);
        wait_idle();
        load_settings(24'h00_0400, 24'h00_0400, 24'h00_0400, 24'h00_0400, 10'd4, 10'd4);
        random_phase(140);
        wait_idle();
        load_settings(24'h00_0000, 24'hFF_FFFF, 24'hFF_FFFF, 24'h00_0000, 10'd1, 10'd512);
        random_phase(120);
        wait_idle();
        load_settings(24'hFF_FFFF, 24'h00_0200, 24'h00_0000, 24'h00_0080, 10'd512, 10'd1);
        random_phase(120);
        wait_idle();
        load_settings(FOCAL_RESET, FOCAL_RESET, CENTER_RESET, CENTER_RESET, 10'd16, 10'd16);
        random_phase(160);
        wait_idle();

        if (error_count == 0)
            $display("tb_point_projection_depth_buffer: PASS");
        else
            $display("tb_point_projection_depth_buffer: FAIL");
        $finish;
    end
endmodule
